/* rtl/qds_pkg.sv */
// qds_pkg: shared types, constants and codes for the quadrature distance sampler.
// No dependencies.
package qds_pkg;
    localparam int unsigned MaxBurstDef = 64;
    localparam logic [31:0] StepUm = 32'd5;

    typedef enum logic [1:0] {
        OP_EDGE  = 2'd0,
        OP_POS   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EDGE_RISE_A = 2'd0,
        EDGE_FALL_A = 2'd1,
        EDGE_RISE_B = 2'd2,
        EDGE_FALL_B = 2'd3
    } edge_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NDIV,
        ST_NDONE,
        ST_MUL,
        ST_QDIV,
        ST_EMIT,
        ST_STATUS
    } state_t;

    localparam logic [0:0] REG_SAMPLE_INTERVAL = 1'b0;
endpackage

/* rtl/qds_if.sv */
// qds_if: valid/ready channel carrying a payload of type T.
// Depends on nothing.
interface qds_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/qds_div.sv */
// qds_div: restoring bit-serial divider, one quotient bit per cycle.
// Depends on nothing.
module qds_div #(
    parameter int unsigned NW = 40,
    parameter int unsigned DW = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int unsigned CW = $clog2(NW + 1);
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg;
    logic          busy_reg, busy_next, done_reg;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        busy_next = busy_reg;
        if (start)
        begin
            cnt_next  = CW'(NW);
            q_next    = num;
            r_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one numerator bit in, subtract when it fits
            if (!diff[DW+1])
            begin
                r_next = diff[DW:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= busy_reg && !busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= den;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg[DW-1:0];
endmodule

/* rtl/qds_mul.sv */
// qds_mul: shift-and-add multiplier, one multiplier bit per cycle.
// Depends on nothing.
module qds_mul #(
    parameter int unsigned AW = 33,
    parameter int unsigned BW = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);
    localparam int unsigned CW = $clog2(BW + 1);
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [AW+BW-1:0] acc_reg, sh_reg;
    logic [BW-1:0]    b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(BW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            sh_reg  <= {{BW{1'b0}}, a};
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + sh_reg;
            sh_reg <= {sh_reg[AW+BW-2:0], 1'b0};
            b_reg  <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

/* rtl/quadrature_distance_sampler_top.sv */
// Channels:
//   name   dir  payload                                       handshake
//   in_ch  in   op, edge_req, other_level, position           valid/ready
//   out_ch out  sample_valid, measure, raw_sum, last, clip    valid/ready
//   cfg    in   sample_interval (addr 0)                      APB, pready high
// Sequence: edge, clear and status items go straight to a status output. A position
// update runs a bit-serial divide for n, then per interpolated sample a shift-add
// multiply and a bit-serial divide for the interpolation.
// The shared serial divider sets the rate.
// Reset: rst_n is asynchronous, active low; counters and history clear.
// Stalls: the output register holds a result until taken; the sequencer waits.
// Depends on qds_pkg, qds_if, qds_div, qds_mul.
module quadrature_distance_sampler_top #(
    parameter int unsigned MAX_BURST = qds_pkg::MaxBurstDef
) (
    input  logic        clk,
    input  logic        rst_n,
    qds_if.sink         in_ch,
    qds_if.source       out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qds_pkg::*;

    localparam int unsigned BW = $clog2(MAX_BURST + 1);
    localparam int unsigned NW = 34;   // advance (33b) + residual
    localparam int unsigned QW = 33 + BW + 1;

    state_t state_reg, state_next;

    logic [23:0] interval_reg;
    logic [31:0] count_a_reg, count_b_reg;
    logic [31:0] last_pos_reg, last_emit_reg;
    logic [23:0] residual_reg;
    logic [31:0] cur_reg, pos_reg;
    logic [BW-1:0] n_reg, i_reg;
    logic        clip_reg, neg_reg;
    logic [32:0] dabs_reg;

    logic        ov_reg;
    logic        o_sv_reg, o_last_reg, o_clip_reg;
    logic [31:0] o_meas_reg, o_sum_reg;

    logic [31:0] sum_now;
    assign sum_now = count_a_reg + count_b_reg;

    // APB: writes in the access phase, reads return the interval
    assign pready = 1'b1;
    assign prdata = {8'd0, interval_reg};
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SAMPLE_INTERVAL);

    // advance
    logic [32:0] adv_raw, adv;
    logic        adv_neg;
    assign adv_raw = {pos_reg[31], pos_reg} - {last_pos_reg[31], last_pos_reg};
    assign adv_neg = adv_raw[32];
    assign adv     = adv_neg ? {pos_reg[31], pos_reg} : adv_raw;

    // divider shared between n and interpolation
    logic          dv_start, dv_busy, dv_done;
    logic [QW-1:0] dv_num, dv_quo;
    logic [QW-1:0] dv_den, dv_rem;
    qds_div #(.NW(QW), .DW(QW)) u_div (
        .clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
        .busy(dv_busy), .done(dv_done), .quo(dv_quo), .rem(dv_rem)
    );

    logic                mu_start, mu_done;
    logic [33+BW-1:0]    mu_prod;
    qds_mul #(.AW(33), .BW(BW)) u_mul (
        .clk, .rst_n, .start(mu_start), .a(dabs_reg), .b(i_reg),
        .done(mu_done), .prod(mu_prod)
    );

    logic in_fire, out_fire;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    logic [NW-1:0] total;
    assign total = {1'b0, adv} + {10'd0, residual_reg};

    logic [32:0] d_full;
    assign d_full = {cur_reg[31], cur_reg} - {last_emit_reg[31], last_emit_reg};

    logic [QW-1:0] n_wide;
    assign n_wide = {{(QW-BW){1'b0}}, n_reg};

    // pending output
    logic          emit_now, emit_sv, emit_last;
    logic [31:0]   emit_meas;
    logic [31:0]   q_mag;
    assign q_mag = dv_quo[31:0];

    always_comb
    begin
        state_next = state_reg;
        dv_start   = 1'b0;
        dv_num     = '0;
        dv_den     = '0;
        emit_now   = 1'b0;
        emit_sv    = 1'b0;
        emit_last  = 1'b1;
        emit_meas  = '0;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    if (op_t'(in_ch.data.op) == OP_POS)
                        state_next = ST_NDIV;
                    else
                        state_next = ST_STATUS;
                end
            ST_NDIV:
            begin
                // start n = total / interval; a zero interval or no positive advance goes to status
                if (interval_reg == 24'd0 || adv[32] || adv == 33'd0)
                    state_next = ST_STATUS;
                else
                begin
                    dv_start   = 1'b1;
                    dv_num     = QW'(total);
                    dv_den     = QW'(interval_reg);
                    state_next = ST_NDONE;
                end
            end
            ST_NDONE:
                if (dv_done)
                begin
                    if (dv_quo == '0)
                        state_next = ST_STATUS;
                    else
                        state_next = ST_MUL;
                end
            ST_MUL:
                if (i_reg == n_reg)
                    state_next = ST_EMIT;
                else if (mu_done)
                begin
                    dv_start   = 1'b1;
                    dv_num     = QW'({mu_prod, 1'b0}) + n_wide;
                    dv_den     = {n_wide[QW-2:0], 1'b0};
                    state_next = ST_QDIV;
                end
            ST_QDIV:
                // the quotient holds once the divider goes idle
                if (!dv_busy && !ov_reg)
                begin
                    emit_now   = 1'b1;
                    emit_sv    = 1'b1;
                    emit_last  = 1'b0;
                    emit_meas  = last_emit_reg + (neg_reg ? -q_mag : q_mag);
                    state_next = ST_MUL;
                end
            ST_EMIT:
                if (!ov_reg)
                begin
                    emit_now   = 1'b1;
                    emit_sv    = 1'b1;
                    emit_meas  = cur_reg;
                    state_next = ST_IDLE;
                end
            ST_STATUS:
                if (!ov_reg)
                begin
                    emit_now   = 1'b1;
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            interval_reg  <= 24'd1;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            last_pos_reg  <= '0;
            last_emit_reg <= '0;
            residual_reg  <= '0;
            ov_reg        <= 1'b0;
            clip_reg      <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
                interval_reg <= pwdata[23:0];
            if (out_fire)
                ov_reg <= 1'b0;
            if (emit_now)
                ov_reg <= 1'b1;
            if (state_reg == ST_IDLE && in_fire)
            begin
                clip_reg <= 1'b0;
                unique case (op_t'(in_ch.data.op))
                    OP_EDGE:
                        unique case (edge_t'(in_ch.data.edge_req))
                            EDGE_RISE_A: count_a_reg <= in_ch.data.other_level ?
                                count_a_reg - StepUm : count_a_reg + StepUm;
                            EDGE_FALL_A: count_a_reg <= in_ch.data.other_level ?
                                count_a_reg + StepUm : count_a_reg - StepUm;
                            EDGE_RISE_B: count_b_reg <= in_ch.data.other_level ?
                                count_b_reg + StepUm : count_b_reg - StepUm;
                            EDGE_FALL_B: count_b_reg <= in_ch.data.other_level ?
                                count_b_reg - StepUm : count_b_reg + StepUm;
                            default: ;
                        endcase
                    OP_CLEAR:
                    begin
                        count_a_reg <= '0;
                        count_b_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_NDIV && interval_reg != 24'd0)
            begin
                // a backward move restarts from zero even when nothing is emitted
                if (!adv[32] && adv != 33'd0)
                    last_pos_reg <= pos_reg;
                else if (adv_neg)
                    last_pos_reg <= '0;
            end
            if (state_reg == ST_NDONE && dv_done)
            begin
                residual_reg <= dv_rem[23:0];
                i_reg        <= BW'(1);
                if (dv_quo > QW'(MAX_BURST))
                begin
                    n_reg    <= BW'(MAX_BURST);
                    clip_reg <= 1'b1;
                end
                else
                    n_reg <= dv_quo[BW-1:0];
            end
            if (state_reg == ST_QDIV && emit_now)
                i_reg <= i_reg + 1'b1;
            if (state_reg == ST_EMIT && emit_now)
                last_emit_reg <= cur_reg;
        end
    end

    // start a multiply on entry to ST_MUL with i below n
    logic mul_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_go_reg <= 1'b0;
        else
            mul_go_reg <= (state_next == ST_MUL) && (state_reg != ST_MUL);
    end
    assign mu_start = mul_go_reg && (i_reg != n_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_fire)
            pos_reg <= in_ch.data.position;
        if (state_reg == ST_NDIV)
            cur_reg <= sum_now;
        if (state_reg == ST_NDONE)
        begin
            neg_reg  <= d_full[32];
            dabs_reg <= d_full[32] ? -d_full : d_full;
        end
        if (emit_now)
        begin
            o_sv_reg   <= emit_sv;
            o_meas_reg <= emit_meas;
            o_sum_reg  <= sum_now;
            o_last_reg <= emit_last;
            o_clip_reg <= emit_sv & clip_reg;
        end
    end

    assign out_ch.valid             = ov_reg;
    assign out_ch.data.sample_valid = o_sv_reg;
    assign out_ch.data.measure      = o_meas_reg;
    assign out_ch.data.raw_sum      = o_sum_reg;
    assign out_ch.data.last         = o_last_reg;
    assign out_ch.data.burst_clipped = o_clip_reg;

    // a new result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ch.ready |=> ov_reg && $stable(o_meas_reg))
        else $error("result overwritten");
    // no input is taken while a burst is running
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ch.ready)
        else $error("input taken mid burst");
    // interpolation index never passes the burst length
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_QDIV) |-> i_reg <= n_reg)
        else $error("index overrun");
endmodule
